// ----- hw/rtl/bxds_pkg.sv -----
package bxds_pkg;

  // Register widths and reset values of the configuration port.
  localparam int unsigned COLS_W = 12;
  localparam int unsigned ROWS_W = 13;
  localparam logic [COLS_W-1:0] COLS_RESET = 12'd2048;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 13'd4096;

  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS = 4'd1;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned SUM_W  = CHAN_W + 1;
  localparam int unsigned NCHAN  = 3;

  // Queue between the front and the back part.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam logic [QPTR_W:0] QUEUE_FULL = 3'd4;

  typedef struct packed {
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
  } pix_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              row_end;
    logic              image_end;
  } pix_out_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_t;

  typedef logic [NCHAN-1:0][SUM_W-1:0] sums_t;

  // One classified item travelling from the front to the back part.
  typedef struct packed {
    logic  wr_line;   // store the pair sums in the line store, no result
    logic  add_line;  // add the stored sums of the row above
    logic  halve;     // sums hold a horizontal pair
    logic  row_end;
    logic  image_end;
    sums_t sum;
  } op_t;

endpackage

// ----- hw/rtl/bxds_stream_if.sv -----
interface bxds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/bxds_fifo.sv -----
module bxds_fifo import bxds_pkg::*; #(
  parameter int unsigned WIDTH = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  logic [WIDTH-1:0]  slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QUEUE_FULL);
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + (QPTR_W + 1)'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - (QPTR_W + 1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue overrun");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue underrun");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_FULL) else $error("queue count out of range");

endmodule

// ----- hw/rtl/bxds_front.sv -----
module bxds_front import bxds_pkg::*; #(
  parameter int unsigned MAX_COLS = 2048,
  parameter int unsigned MAX_ROWS = 4096,
  parameter int unsigned IDX_W    = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  bxds_stream_if.sink      pix_i,
  bxds_stream_if.sink      cfg_i,
  output logic             push_o,
  output op_t              op_o,
  output logic [IDX_W-1:0] idx_o,
  input  logic             full_i
);

  localparam int unsigned ColW    = $clog2(MAX_COLS);
  localparam int unsigned ColLimW = ColW + 1;
  localparam int unsigned RowW    = $clog2(MAX_ROWS);
  localparam int unsigned RowLimW = RowW + 1;

  logic [COLS_W-1:0]  image_cols_q;
  logic [ROWS_W-1:0]  image_rows_q;
  logic [ColW-1:0]    col_q, col_d;
  logic [RowW-1:0]    row_q, row_d;
  pix_in_t            pending_q;
  pix_in_t            px;
  logic [ColLimW-1:0] cols_eff;
  logic [RowLimW-1:0] rows_eff;
  logic               last_col, last_row;
  logic               accept, store_left;

  assign cfg_i.ready = 1'b1;
  assign pix_i.ready = !full_i;
  assign accept      = pix_i.valid && pix_i.ready;
  assign px          = pix_i.payload;

  // A size of zero behaves as one, a size above the maximum as the maximum.
  always_comb begin
    if (image_cols_q == '0) begin
      cols_eff = ColLimW'(1);
    end else if (int'(image_cols_q) > int'(MAX_COLS)) begin
      cols_eff = ColLimW'(MAX_COLS);
    end else begin
      cols_eff = ColLimW'(image_cols_q);
    end
    if (image_rows_q == '0) begin
      rows_eff = RowLimW'(1);
    end else if (int'(image_rows_q) > int'(MAX_ROWS)) begin
      rows_eff = RowLimW'(MAX_ROWS);
    end else begin
      rows_eff = RowLimW'(image_rows_q);
    end
  end

  // Positions left beyond the end by a size change count as the last ones.
  assign last_col   = ({1'b0, col_q} + ColLimW'(1)) >= cols_eff;
  assign last_row   = ({1'b0, row_q} + RowLimW'(1)) >= rows_eff;
  assign store_left = !col_q[0] && !last_col;

  always_comb begin
    op_o.wr_line   = !row_q[0] && !last_row;
    op_o.add_line  = row_q[0];
    op_o.halve     = col_q[0];
    op_o.row_end   = last_col;
    op_o.image_end = last_col && last_row;
    op_o.sum[0] = {1'b0, px.red_in} + (col_q[0] ? {1'b0, pending_q.red_in} : '0);
    op_o.sum[1] = {1'b0, px.green_in} + (col_q[0] ? {1'b0, pending_q.green_in} : '0);
    op_o.sum[2] = {1'b0, px.blue_in} + (col_q[0] ? {1'b0, pending_q.blue_in} : '0);
  end

  assign idx_o  = IDX_W'(col_q >> 1);
  assign push_o = accept && !store_left;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + RowW'(1);
    end else begin
      col_d = col_q + ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_cols_q <= COLS_RESET;
      image_rows_q <= ROWS_RESET;
      col_q        <= '0;
      row_q        <= '0;
      pending_q    <= '0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.payload.index)
          REG_IMAGE_COLS: image_cols_q <= cfg_i.payload.data[COLS_W-1:0];
          REG_IMAGE_ROWS: image_rows_q <= cfg_i.payload.data[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        col_q <= col_d;
        row_q <= row_d;
        if (store_left) begin
          pending_q <= px;
        end
      end
    end
  end

endmodule

// ----- hw/rtl/bxds_back.sv -----
module bxds_back import bxds_pkg::*; #(
  parameter int unsigned MAX_COLS = 2048,
  parameter int unsigned IDX_W    = 10
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  op_t              head_op_i,
  input  logic [IDX_W-1:0] head_idx_i,
  output logic             pop_o,
  bxds_stream_if.source    res_o
);

  localparam int unsigned LineDepth = (MAX_COLS + 1) / 2;

  sums_t    line_mem [LineDepth];
  sums_t    rd_q;
  op_t      a_op_q;
  logic     a_valid_q;
  pix_out_t out_q, out_d;
  logic     out_valid_q;
  logic     out_free, a_free;
  logic [NCHAN-1:0][SUM_W:0] tot;
  logic [1:0] shamt;

  assign out_free = !out_valid_q || res_o.ready;
  assign a_free   = !a_valid_q || out_free;
  // Line writes leave nothing behind, so they drain even while results stall.
  assign pop_o    = !empty_i && (head_op_i.wr_line || a_free);

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      if (head_op_i.wr_line) begin
        line_mem[head_idx_i] <= head_op_i.sum;
      end else begin
        rd_q <= line_mem[head_idx_i];
      end
    end
  end

  always_comb begin
    shamt = {1'b0, a_op_q.halve} + {1'b0, a_op_q.add_line};
    for (int ch = 0; ch < NCHAN; ch++) begin
      tot[ch] = {1'b0, a_op_q.sum[ch]} + (a_op_q.add_line ? {1'b0, rd_q[ch]} : '0);
    end
    out_d.red_out   = CHAN_W'(tot[0] >> shamt);
    out_d.green_out = CHAN_W'(tot[1] >> shamt);
    out_d.blue_out  = CHAN_W'(tot[2] >> shamt);
    out_d.row_end   = a_op_q.row_end;
    out_d.image_end = a_op_q.image_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid_q <= pop_o && !head_op_i.wr_line;
      end
      if (out_free) begin
        out_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_free && pop_o && !head_op_i.wr_line) begin
      a_op_q <= head_op_i;
    end
    if (out_free && a_valid_q) begin
      out_q <= out_d;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  a_emit_enters_stage: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !head_op_i.wr_line |=> a_valid_q) else $error("popped item lost");

  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_valid_q && !out_free |=> a_valid_q && $stable(a_op_q))
    else $error("stalled item changed");

  a_image_end_ends_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.image_end |-> out_q.row_end)
    else $error("image end without row end");

endmodule

// ----- hw/rtl/box_average_downscale_2x.sv -----
// Channel  Dir  Payload                                         Role
// pix_i    in   red_in, green_in, blue_in                       input pixels, raster order
// cfg_i    in   index, data                                     size register writes
// res_o    out  red_out, green_out, blue_out, row_end, image_end averaged pixels
//
// One pixel is accepted per cycle while the queue is not full; the pixel that
// completes a block passes the queue, line store read and output register.
// The line store has one port used once per cycle; line writes drain even while
// results are stalled, and a four-item queue lets the input run on meanwhile.
// Reset clears positions, queue and pipeline; the line store is not cleared.
module box_average_downscale_2x import bxds_pkg::*; #(
  parameter int unsigned MAX_COLS = 2048,
  parameter int unsigned MAX_ROWS = 4096
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bxds_stream_if.sink   pix_i,
  bxds_stream_if.sink   cfg_i,
  bxds_stream_if.source res_o
);

  localparam int unsigned LineDepth = (MAX_COLS + 1) / 2;
  localparam int unsigned IdxW      = (LineDepth > 1) ? $clog2(LineDepth) : 1;
  localparam int unsigned EntryW    = $bits(op_t) + IdxW;

  logic              push, pop, full, empty;
  op_t               push_op, head_op;
  logic [IdxW-1:0]   push_idx, head_idx;
  logic [EntryW-1:0] head_entry;

  bxds_front #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS),
    .IDX_W    (IdxW)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix_i  (pix_i),
    .cfg_i  (cfg_i),
    .push_o (push),
    .op_o   (push_op),
    .idx_o  (push_idx),
    .full_i (full)
  );

  bxds_fifo #(
    .WIDTH (EntryW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({push_op, push_idx}),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (head_entry),
    .empty_o (empty)
  );

  assign head_op  = op_t'(head_entry[EntryW-1:IdxW]);
  assign head_idx = head_entry[IdxW-1:0];

  bxds_back #(
    .MAX_COLS (MAX_COLS),
    .IDX_W    (IdxW)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (empty),
    .head_op_i  (head_op),
    .head_idx_i (head_idx),
    .pop_o      (pop),
    .res_o      (res_o)
  );

endmodule
